// ===== rtl/tfn_pkg.sv =====
// Package for the triangle face normal block: sizes, widths, request codes and index helpers.
// Used by tfn_norm and triangle_face_normal; depends on nothing.
`default_nettype none
package tfn_pkg;

    localparam int VERTEX_COUNT = 4096;
    localparam int ADDR_W       = $clog2(VERTEX_COUNT);
    localparam int INDEX_W      = 12;
    localparam int COORD_W      = 16;
    localparam int VERTEX_W     = 3 * COORD_W;
    localparam int EDGE_W       = COORD_W + 1;
    localparam int CROSS_W      = 36;
    localparam int MAG_W        = 34;
    localparam int SQ_W         = 68;
    localparam int QUO_W        = 31;
    localparam int COMP_W       = 16;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_FACE = 1'b1;

    function automatic logic index_ok(input logic [INDEX_W-1:0] idx);
        logic [31:0] wide;
        wide = {{(32-INDEX_W){1'b0}}, idx};
        return wide < 32'(VERTEX_COUNT);
    endfunction

    function automatic logic [ADDR_W-1:0] index_addr(input logic [INDEX_W-1:0] idx);
        logic [31:0] wide;
        wide = {{(32-INDEX_W){1'b0}}, idx};
        return wide[ADDR_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/tfn_norm.sv =====
// Normalizes one cross product component: restoring division of the scaled square
// by the squared length, then a digit-by-digit square root, sharing one subtractor.
// Depends on tfn_pkg.
`default_nettype none
module tfn_norm import tfn_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [SQ_W-1:0]          sq,
    input  logic [SQ_W-1:0]          sum,
    input  logic                     neg,
    output logic                     done,
    output logic signed [COMP_W-1:0] comp
);

    localparam logic [1:0] N_IDLE = 2'd0;
    localparam logic [1:0] N_DIV  = 2'd1;
    localparam logic [1:0] N_SQRT = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic [4:0]            cnt_reg;
    logic [SQ_W:0]         rem_reg;
    logic [QUO_W-1:0]      quo_reg;
    logic [31:0]           d_reg;
    logic [19:0]           srem_reg;
    logic [16:0]           root_reg;
    logic                  neg_reg;
    logic                  done_reg;
    logic signed [COMP_W-1:0] comp_reg;

    logic [SQ_W:0]         div_trial;
    logic [19:0]           sqrt_trial;
    logic [SQ_W:0]         sub_a, sub_b;
    logic [SQ_W+1:0]       diff;
    logic                  ge;
    logic [QUO_W-1:0]      quo_next;
    logic [16:0]           root_next;
    logic [17:0]           rounded;
    logic [COMP_W-1:0]     mag;

    always_comb begin
        div_trial  = (cnt_reg == 5'd0) ? rem_reg : {rem_reg[SQ_W-1:0], 1'b0};
        sqrt_trial = {srem_reg[17:0], d_reg[31:30]};
        if (state_reg == N_SQRT) begin
            sub_a = {{(SQ_W-19){1'b0}}, sqrt_trial};
            sub_b = {{(SQ_W-17){1'b0}}, root_reg[15:0], 2'b01};
        end else begin
            sub_a = div_trial;
            sub_b = {1'b0, sum};
        end
        diff      = {1'b0, sub_a} - {1'b0, sub_b};
        ge        = ~diff[SQ_W+1];
        quo_next  = {quo_reg[QUO_W-2:0], ge};
        root_next = {root_reg[15:0], ge};
        rounded   = {1'b0, root_next} + 18'd1;
        mag       = rounded[16:1];
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            N_IDLE: begin
                if (start) begin
                    state_next = N_DIV;
                end
            end
            N_DIV: begin
                if (cnt_reg == 5'(QUO_W - 1)) begin
                    state_next = N_SQRT;
                end
            end
            N_SQRT: begin
                if (cnt_reg == 5'd15) begin
                    state_next = N_IDLE;
                end
            end
            default: state_next = N_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= N_IDLE;
            cnt_reg   <= 5'd0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= (state_reg == N_SQRT) && (cnt_reg == 5'd15);
            if (state_next != state_reg) begin
                cnt_reg <= 5'd0;
            end else if (state_reg != N_IDLE) begin
                cnt_reg <= cnt_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            N_IDLE: begin
                if (start) begin
                    rem_reg  <= {1'b0, sq};
                    quo_reg  <= '0;
                    neg_reg  <= neg;
                end
            end
            N_DIV: begin
                rem_reg <= ge ? diff[SQ_W:0] : div_trial;
                quo_reg <= quo_next;
                if (cnt_reg == 5'(QUO_W - 1)) begin
                    d_reg    <= {1'b0, quo_next};
                    srem_reg <= '0;
                    root_reg <= '0;
                end
            end
            N_SQRT: begin
                srem_reg <= ge ? diff[19:0] : sqrt_trial;
                root_reg <= root_next;
                d_reg    <= {d_reg[29:0], 2'b00};
                if (cnt_reg == 5'd15) begin
                    comp_reg <= neg_reg ? -$signed(mag) : $signed(mag);
                end
            end
            default: begin
            end
        endcase
    end

    assign done = done_reg;
    assign comp = comp_reg;

endmodule
`default_nettype wire

// ===== rtl/triangle_face_normal.sv =====
// Triangle face normal block: vertex store, cross product and square sequencer.
// Depends on tfn_pkg and tfn_norm.
//
// A request on the s_ channel either loads a vertex (s_operation low) into the
// store at s_first_index or asks for the unit normal of the face whose corners
// are the three indices (s_operation high). A load gives no result. A face
// request gives one result on the m_ channel: the normal as signed Q1.14,
// rounded to nearest, and a copy of s_last_face.
// A face goes from acceptance to m_valid in these steps: read the corners one
// at a time from the single store read port, form the edges, then the cross
// product and the squares on the shared 36 x 18 multiplier, then for each
// component 31 division and 16 square root steps of the shared subtractor,
// and last the load of the output register. A degenerate face skips the
// division and the square root and gives a zero normal. s_ready is low while
// a face is in work, so no request is taken until that face has left it.
// The result waits in an output register, so new requests are taken while the
// receiver stalls; a finished face waits until that register is free.
// Reset empties the pipeline and clears m_valid; store contents stay undefined.
`default_nettype none
module triangle_face_normal import tfn_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_operation,
    input  logic [INDEX_W-1:0]        s_first_index,
    input  logic [INDEX_W-1:0]        s_second_index,
    input  logic [INDEX_W-1:0]        s_third_index,
    input  logic signed [COORD_W-1:0] s_coord_x,
    input  logic signed [COORD_W-1:0] s_coord_y,
    input  logic signed [COORD_W-1:0] s_coord_z,
    input  logic                      s_last_face,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [COMP_W-1:0]  m_normal_x,
    output logic signed [COMP_W-1:0]  m_normal_y,
    output logic signed [COMP_W-1:0]  m_normal_z,
    output logic                      m_end_of_mesh
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_READ   = 3'd1;
    localparam logic [2:0] ST_UV     = 3'd2;
    localparam logic [2:0] ST_CROSS  = 3'd3;
    localparam logic [2:0] ST_SQUARE = 3'd4;
    localparam logic [2:0] ST_NORM   = 3'd5;
    localparam logic [2:0] ST_OUT    = 3'd6;

    logic [2:0]                state_reg;
    logic [2:0]                cnt_reg;
    logic [1:0]                comp_idx_reg;
    logic                      wait_reg;
    logic                      m_valid_reg;

    logic [VERTEX_W-1:0]       vstore_mem [VERTEX_COUNT];
    logic [VERTEX_W-1:0]       rd_data_reg;
    logic                      rd_ok_reg;
    logic [INDEX_W-1:0]        idx_reg [3];
    logic                      last_reg;
    logic [VERTEX_W-1:0]       vtx_reg [3];
    logic signed [EDGE_W-1:0]  u_reg [3];
    logic signed [EDGE_W-1:0]  v_reg [3];
    logic signed [CROSS_W-1:0] n_reg [3];
    logic [SQ_W-1:0]           sq_reg [3];
    logic [SQ_W-1:0]           sum_reg;
    logic signed [COMP_W-1:0]  comp_reg [3];
    logic signed [COMP_W-1:0]  out_x_reg, out_y_reg, out_z_reg;
    logic                      out_last_reg;

    logic signed [53:0]        prod_reg;
    logic [1:0]                tgt_reg;
    logic                      neg_reg;
    logic                      part_reg;
    logic                      acc_en_reg;
    logic                      acc_sq_reg;

    logic                      s_accept;
    logic [INDEX_W-1:0]        rd_index;
    logic signed [35:0]        mul_a;
    logic signed [17:0]        mul_b;
    logic [1:0]                mul_tgt;
    logic                      mul_neg;
    logic                      mul_en;
    logic signed [CROSS_W-1:0] n_sel;
    logic [CROSS_W-1:0]        n_abs;
    logic [MAG_W-1:0]          a_mag;
    logic [SQ_W-1:0]           addend;
    logic                      sum_zero;
    logic                      norm_start;
    logic                      norm_done;
    logic signed [COMP_W-1:0]  norm_comp;
    logic                      out_load;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign sum_zero = (sum_reg == '0);
    assign norm_start = (state_reg == ST_NORM) && !wait_reg && !sum_zero;
    assign out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    always_comb begin
        case (cnt_reg)
            3'd0:    rd_index = idx_reg[0];
            3'd1:    rd_index = idx_reg[1];
            default: rd_index = idx_reg[2];
        endcase
    end

    always_ff @(posedge aclk) begin
        if (s_accept && s_operation == OP_LOAD && index_ok(s_first_index)) begin
            vstore_mem[index_addr(s_first_index)] <= {s_coord_z, s_coord_y, s_coord_x};
        end
        if (state_reg == ST_READ && cnt_reg < 3'd3) begin
            rd_data_reg <= vstore_mem[index_addr(rd_index)];
            rd_ok_reg   <= index_ok(rd_index);
        end
    end

    always_comb begin
        n_sel = n_reg[0];
        case (cnt_reg[2:1])
            2'd1:    n_sel = n_reg[1];
            2'd2:    n_sel = n_reg[2];
            default: n_sel = n_reg[0];
        endcase
        n_abs = n_sel[CROSS_W-1] ? 36'(-n_sel) : 36'(n_sel);
        a_mag = n_abs[MAG_W-1:0];
        mul_a   = '0;
        mul_b   = '0;
        mul_tgt = 2'd0;
        mul_neg = 1'b0;
        mul_en  = ((state_reg == ST_CROSS) || (state_reg == ST_SQUARE)) && (cnt_reg < 3'd6);
        if (state_reg == ST_CROSS) begin
            case (cnt_reg)
                3'd0: begin
                    mul_a = 36'(u_reg[1]); mul_b = 18'(v_reg[2]);
                end
                3'd1: begin
                    mul_a = 36'(u_reg[2]); mul_b = 18'(v_reg[1]); mul_neg = 1'b1;
                end
                3'd2: begin
                    mul_a = 36'(u_reg[2]); mul_b = 18'(v_reg[0]); mul_tgt = 2'd1;
                end
                3'd3: begin
                    mul_a = 36'(u_reg[0]); mul_b = 18'(v_reg[2]); mul_tgt = 2'd1;
                    mul_neg = 1'b1;
                end
                3'd4: begin
                    mul_a = 36'(u_reg[0]); mul_b = 18'(v_reg[1]); mul_tgt = 2'd2;
                end
                3'd5: begin
                    mul_a = 36'(u_reg[1]); mul_b = 18'(v_reg[0]); mul_tgt = 2'd2;
                    mul_neg = 1'b1;
                end
                default: begin
                end
            endcase
        end else begin
            mul_a   = {2'b00, a_mag};
            mul_b   = cnt_reg[0] ? {1'b0, a_mag[33:17]} : {1'b0, a_mag[16:0]};
            mul_tgt = cnt_reg[2:1];
        end
        addend = part_reg ? {prod_reg[50:0], 17'd0} : {17'd0, prod_reg[50:0]};
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        tgt_reg  <= mul_tgt;
        neg_reg  <= mul_neg;
        part_reg <= cnt_reg[0];
        if (s_accept && s_operation == OP_FACE) begin
            idx_reg[0] <= s_first_index;
            idx_reg[1] <= s_second_index;
            idx_reg[2] <= s_third_index;
            last_reg   <= s_last_face;
        end
        if (state_reg == ST_READ && cnt_reg != 3'd0) begin
            case (cnt_reg)
                3'd1:    vtx_reg[0] <= rd_ok_reg ? rd_data_reg : '0;
                3'd2:    vtx_reg[1] <= rd_ok_reg ? rd_data_reg : '0;
                default: vtx_reg[2] <= rd_ok_reg ? rd_data_reg : '0;
            endcase
        end
        if (state_reg == ST_UV) begin
            for (int j = 0; j < 3; j++) begin
                u_reg[j] <= $signed({vtx_reg[1][j*COORD_W+COORD_W-1],
                                     vtx_reg[1][j*COORD_W +: COORD_W]})
                          - $signed({vtx_reg[0][j*COORD_W+COORD_W-1],
                                     vtx_reg[0][j*COORD_W +: COORD_W]});
                v_reg[j] <= $signed({vtx_reg[2][j*COORD_W+COORD_W-1],
                                     vtx_reg[2][j*COORD_W +: COORD_W]})
                          - $signed({vtx_reg[0][j*COORD_W+COORD_W-1],
                                     vtx_reg[0][j*COORD_W +: COORD_W]});
                n_reg[j]  <= '0;
                sq_reg[j] <= '0;
            end
            sum_reg <= '0;
        end else if (acc_en_reg && !acc_sq_reg) begin
            n_reg[tgt_reg] <= neg_reg ? n_reg[tgt_reg] - prod_reg[CROSS_W-1:0]
                                      : n_reg[tgt_reg] + prod_reg[CROSS_W-1:0];
        end else if (acc_en_reg) begin
            sq_reg[tgt_reg] <= sq_reg[tgt_reg] + addend;
            sum_reg         <= sum_reg + addend;
        end
        if (state_reg == ST_NORM) begin
            if (!wait_reg && sum_zero) begin
                comp_reg[comp_idx_reg] <= '0;
            end else if (wait_reg && norm_done) begin
                comp_reg[comp_idx_reg] <= norm_comp;
            end
        end
        if (out_load) begin
            out_x_reg    <= comp_reg[0];
            out_y_reg    <= comp_reg[1];
            out_z_reg    <= comp_reg[2];
            out_last_reg <= last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= 3'd0;
            comp_idx_reg <= 2'd0;
            wait_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
            acc_en_reg   <= 1'b0;
            acc_sq_reg   <= 1'b0;
        end else begin
            acc_en_reg <= mul_en;
            acc_sq_reg <= (state_reg == ST_SQUARE);
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    cnt_reg <= 3'd0;
                    if (s_accept && s_operation == OP_FACE) begin
                        state_reg <= ST_READ;
                    end
                end
                ST_READ: begin
                    cnt_reg <= cnt_reg + 3'd1;
                    if (cnt_reg == 3'd3) begin
                        cnt_reg   <= 3'd0;
                        state_reg <= ST_UV;
                    end
                end
                ST_UV: begin
                    state_reg <= ST_CROSS;
                end
                ST_CROSS: begin
                    cnt_reg <= cnt_reg + 3'd1;
                    if (cnt_reg == 3'd6) begin
                        cnt_reg   <= 3'd0;
                        state_reg <= ST_SQUARE;
                    end
                end
                ST_SQUARE: begin
                    cnt_reg <= cnt_reg + 3'd1;
                    if (cnt_reg == 3'd6) begin
                        cnt_reg      <= 3'd0;
                        comp_idx_reg <= 2'd0;
                        wait_reg     <= 1'b0;
                        state_reg    <= ST_NORM;
                    end
                end
                ST_NORM: begin
                    if (norm_start) begin
                        wait_reg <= 1'b1;
                    end else if (sum_zero || norm_done) begin
                        wait_reg <= 1'b0;
                        if (comp_idx_reg == 2'd2) begin
                            state_reg <= ST_OUT;
                        end else begin
                            comp_idx_reg <= comp_idx_reg + 2'd1;
                        end
                    end
                end
                ST_OUT: begin
                    if (out_load) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    tfn_norm u_norm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (norm_start),
        .sq      (sq_reg[comp_idx_reg]),
        .sum     (sum_reg),
        .neg     (n_reg[comp_idx_reg][CROSS_W-1]),
        .done    (norm_done),
        .comp    (norm_comp)
    );

    assign m_valid       = m_valid_reg;
    assign m_normal_x    = out_x_reg;
    assign m_normal_y    = out_y_reg;
    assign m_normal_z    = out_z_reg;
    assign m_end_of_mesh = out_last_reg;

`ifndef SYNTHESIS
    a_comp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        norm_done |-> (norm_comp <= 16'sd16384 && norm_comp >= -16'sd16384))
        else $error("Normal component out of unit range.");
    a_start_in_norm: assert property (@(posedge aclk) disable iff (!aresetn)
        norm_start |-> (state_reg == ST_NORM && !sum_zero))
        else $error("Normalizer started outside the normalize phase.");
    a_out_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (m_valid_reg && state_reg == ST_IDLE))
        else $error("Finished face did not reach the output register.");
`endif

endmodule
`default_nettype wire
